[rtl/core/rth_pkg.sv]
// Package for the RGB to HSL pixel converter: widths, hue sector constants and types.
package rth_pkg;

	localparam int unsigned ChanW    = 8;
	localparam int unsigned HueW     = 15;
	localparam int unsigned SatW     = 17;
	localparam int unsigned SumW     = 9;
	// one quotient bit per divider stage; saturation needs 17
	localparam int unsigned DivSteps = 17;
	localparam int unsigned HueQW    = 12;
	localparam int unsigned HueNumW  = 20;
	localparam int unsigned RemW     = 9;

	localparam logic [11:0]     HueSector = 12'd3840;
	localparam logic [HueW-1:0] HueRed    = 15'd0;
	localparam logic [HueW-1:0] HueGreen  = 15'd7680;
	localparam logic [HueW-1:0] HueBlue   = 15'd15360;
	localparam logic [HueW-1:0] HueTurn   = 15'd23040;
	localparam logic [SumW-1:0] SumHalf   = 9'd255;
	localparam logic [SumW-1:0] SumFull   = 9'd510;

	typedef struct packed {
		logic [HueW-1:0] offset;
		logic            neg;
		logic            gray;
		logic [SumW-1:0] sum;
	} rth_side_t;

endpackage

[rtl/core/rgb_to_hsl_pixel.sv]
// RGB to HSL pixel converter: min/max front end, pipelined restoring dividers, hue assembly.
//
// Takes one pixel per clock unless stalled and returns hue (1/64 degree), saturation (1/65536)
// and max+min. The result reaches the outputs through nineteen registers: one prepare
// stage, 17 divider stages that each settle one quotient bit of both the hue and the
// saturation division, and an output register. The whole pipe advances whenever the
// output register is empty or its result is being taken, so throughput is one pixel
// per cycle without stalls.
module rgb_to_hsl_pixel
	import rth_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  logic [ChanW-1:0]  red_in,
	input  logic [ChanW-1:0]  green_in,
	input  logic [ChanW-1:0]  blue_in,
	output logic              hsl_valid,
	input  logic              hsl_stall,
	output logic [HueW-1:0]   hue_out,
	output logic [SatW-1:0]   sat_out,
	output logic [SumW-1:0]   light_sum_out
);

	logic advance;

	// prepare stage signals
	logic [ChanW-1:0]   mx, mn, dlt, x, den;
	logic [SumW-1:0]    sum;
	rth_side_t          side;
	logic [HueNumW-1:0] hnum;

	// divider pipeline, entry 0 is the prepare register
	logic [RemW-1:0]     hrem_s [0:DivSteps];
	logic [SatW-1:0]     hlow_s [0:DivSteps];
	logic [SatW-1:0]     hq_s   [0:DivSteps];
	logic [ChanW-1:0]    hd_s   [0:DivSteps];
	logic [RemW-1:0]     srem_s [0:DivSteps];
	logic [SatW-1:0]     slow_s [0:DivSteps];
	logic [SatW-1:0]     sq_s   [0:DivSteps];
	logic [ChanW-1:0]    sd_s   [0:DivSteps];
	rth_side_t           side_s [0:DivSteps];
	logic                v_s    [0:DivSteps];

	logic [RemW-1:0]     hrem_nx [0:DivSteps-1];
	logic                hbit_nx [0:DivSteps-1];
	logic [RemW-1:0]     srem_nx [0:DivSteps-1];
	logic                sbit_nx [0:DivSteps-1];

	logic [HueQW-1:0]    hq_fin;
	logic [HueW-1:0]     hue_fin;
	logic [HueW-1:0]     step_fin;

	logic [HueW-1:0]     hue_q;
	logic [SatW-1:0]     sat_q;
	logic [SumW-1:0]     sum_q;
	logic                valid_q;

	assign advance   = !valid_q || !hsl_stall;
	assign pix_stall = !advance;

	always_comb begin
		mx = red_in;
		mn = red_in;
		if (green_in > mx) mx = green_in;
		if (blue_in > mx) mx = blue_in;
		if (green_in < mn) mn = green_in;
		if (blue_in < mn) mn = blue_in;
		dlt = mx - mn;
		sum = {1'b0, mx} + {1'b0, mn};
		den = (sum <= SumHalf) ? sum[ChanW-1:0] : 8'(SumFull - sum);
		side.sum  = sum;
		side.gray = (dlt == '0);
		// sector offset; a negative numerator term takes the ceiling off the offset
		if (mx == red_in) begin
			side.neg    = (green_in < blue_in);
			side.offset = side.neg ? HueTurn : HueRed;
			x = side.neg ? blue_in - green_in : green_in - blue_in;
		end else if (mx == green_in) begin
			side.neg    = (blue_in < red_in);
			side.offset = HueGreen;
			x = side.neg ? red_in - blue_in : blue_in - red_in;
		end else begin
			side.neg    = (red_in < green_in);
			side.offset = HueBlue;
			x = side.neg ? green_in - red_in : red_in - green_in;
		end
		hnum = HueNumW'(HueSector) * HueNumW'(x);
	end

	always_comb begin
		for (int k = 0; k < DivSteps; k++) begin
			logic [RemW-1:0] ht, st;
			ht = {hrem_s[k][RemW-2:0], hlow_s[k][SatW-1]};
			st = {srem_s[k][RemW-2:0], slow_s[k][SatW-1]};
			hbit_nx[k] = (ht >= {1'b0, hd_s[k]});
			sbit_nx[k] = (st >= {1'b0, sd_s[k]});
			hrem_nx[k] = hbit_nx[k] ? ht - {1'b0, hd_s[k]} : ht;
			srem_nx[k] = sbit_nx[k] ? st - {1'b0, sd_s[k]} : st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DivSteps; k++) v_s[k] <= 1'b0;
		end else if (advance) begin
			v_s[0] <= pix_valid;
			for (int k = 0; k < DivSteps; k++) v_s[k+1] <= v_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hrem_s[0] <= RemW'(hnum[HueNumW-1:SatW]);
			hlow_s[0] <= hnum[SatW-1:0];
			hq_s[0]   <= '0;
			hd_s[0]   <= dlt;
			srem_s[0] <= {2'b00, dlt[ChanW-1:1]};
			slow_s[0] <= {dlt[0], 16'd0};
			sq_s[0]   <= '0;
			sd_s[0]   <= den;
			side_s[0] <= side;
			for (int k = 0; k < DivSteps; k++) begin
				hrem_s[k+1] <= hrem_nx[k];
				hlow_s[k+1] <= {hlow_s[k][SatW-2:0], 1'b0};
				hq_s[k+1]   <= {hq_s[k][SatW-2:0], hbit_nx[k]};
				hd_s[k+1]   <= hd_s[k];
				srem_s[k+1] <= srem_nx[k];
				slow_s[k+1] <= {slow_s[k][SatW-2:0], 1'b0};
				sq_s[k+1]   <= {sq_s[k][SatW-2:0], sbit_nx[k]};
				sd_s[k+1]   <= sd_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	always_comb begin
		hq_fin   = hq_s[DivSteps][HueQW-1:0];
		step_fin = {3'b000, hq_fin};
		if (side_s[DivSteps].neg) begin
			hue_fin = side_s[DivSteps].offset - step_fin
				- HueW'(hrem_s[DivSteps] != '0);
		end else begin
			hue_fin = side_s[DivSteps].offset + step_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= v_s[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hue_q <= side_s[DivSteps].gray ? '0 : hue_fin;
			sat_q <= side_s[DivSteps].gray ? '0 : sq_s[DivSteps];
			sum_q <= side_s[DivSteps].sum;
		end
	end

	assign hsl_valid     = valid_q;
	assign hue_out       = hue_q;
	assign sat_out       = sat_q;
	assign light_sum_out = sum_q;

endmodule

[tb/rgb_to_hsl_pixel_test.sv]
// Self-checking testbench for the RGB to HSL pixel converter.
`timescale 1ns / 1ps

module rgb_to_hsl_pixel_test
	import rth_pkg::*;
();

	typedef struct packed {
		logic [HueW-1:0] hue;
		logic [SatW-1:0] sat;
		logic [SumW-1:0] sum;
	} hsl_t;

	typedef struct {
		logic [ChanW-1:0] r, g, b;
		bit               known;
		hsl_t             res;
	} pix_row_t;

	localparam int RandItems = 400;
	localparam int CycleLimit = 200000;

	logic             clk;
	logic             arst_n;
	logic             pix_valid;
	logic             pix_stall;
	logic [ChanW-1:0] red_in, green_in, blue_in;
	logic             hsl_valid;
	logic             hsl_stall;
	logic [HueW-1:0]  hue_out;
	logic [SatW-1:0]  sat_out;
	logic [SumW-1:0]  light_sum_out;

	hsl_t     hsl_expected[$];
	int       errors = 0;
	int       cycles = 0;
	bit       quiet = 0;
	bit       hold_off = 0;
	bit       start_hold = 0;
	bit       stim_done = 0;
	pix_row_t dir_rows[$];

	rgb_to_hsl_pixel dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.hsl_valid(hsl_valid), .hsl_stall(hsl_stall),
		.hue_out(hue_out), .sat_out(sat_out), .light_sum_out(light_sum_out)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic hsl_t convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
		int   r, g, b, mx, mn, d, sm, num, den;
		hsl_t o;
		r = r8; g = g8; b = b8;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		sm = mx + mn;
		o.hue = '0;
		o.sat = '0;
		o.sum = sm[SumW-1:0];
		if (d != 0) begin
			if (mx == r) num = 3840 * (g - b) + ((g >= b) ? 0 : 23040 * d);
			else if (mx == g) num = 3840 * (b - r) + 7680 * d;
			else num = 3840 * (r - g) + 15360 * d;
			o.hue = HueW'(num / d);
			den = (sm <= 255) ? sm : 510 - sm;
			o.sat = SatW'((65536 * d) / den);
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	task automatic add_row(int r, int g, int b, bit known = 0, int h = 0, int s = 0, int l = 0);
		pix_row_t row;
		row.r = ChanW'(r); row.g = ChanW'(g); row.b = ChanW'(b);
		row.known = known;
		row.res = '{hue: HueW'(h), sat: SatW'(s), sum: SumW'(l)};
		dir_rows.push_back(row);
	endtask

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red_in <= r; green_in <= g; blue_in <= b;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
	endtask

	// check each transfer on the result side
	always @(posedge clk) begin
		hsl_t want;
		if (arst_n && hsl_valid && !hsl_stall) begin
			if (hsl_expected.size() == 0) begin
				report_mismatch("unexpected result, hue", hue_out, 0);
			end else begin
				want = hsl_expected.pop_front();
				if (hue_out !== want.hue) report_mismatch("hue", hue_out, want.hue);
				if (sat_out !== want.sat) report_mismatch("sat", sat_out, want.sat);
				if (light_sum_out !== want.sum)
					report_mismatch("light_sum", light_sum_out, want.sum);
			end
		end
	end

	// predict on every input transfer
	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall)
			hsl_expected.push_back(convert_pixel(red_in, green_in, blue_in));
	end

	// receiver stalls in bursts
	initial begin
		int n;
		hsl_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hsl_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 5);
				hsl_stall <= 1'b1;
				repeat (n - 1) @(posedge clk);
				@(posedge clk);
				hsl_stall <= 1'b0;
			end else begin
				hsl_stall <= 1'b0;
			end
		end
	end

	// long hold-off on the receiver, counted here
	initial begin
		wait (start_hold);
		hold_off = 1;
		repeat (60) @(posedge clk);
		hold_off = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("rgb_to_hsl_pixel_test: FAIL");
			$finish;
		end
	end

	initial begin
		int c;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		red_in = '0; green_in = '0; blue_in = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(0, 0, 0, 1, 0, 0, 0);
		add_row(255, 255, 255, 1, 0, 0, 510);
		add_row(128, 128, 128, 1, 0, 0, 256);
		add_row(255, 0, 0, 1, 0, 65536, 255);
		add_row(0, 255, 0, 1, 7680, 65536, 255);
		add_row(0, 0, 255, 1, 15360, 65536, 255);
		add_row(255, 255, 0);
		add_row(0, 255, 255);
		add_row(255, 0, 255);
		add_row(255, 0, 1);
		add_row(255, 1, 0);
		add_row(1, 0, 0);
		add_row(255, 254, 254);
		add_row(254, 255, 255);
		add_row(128, 127, 127);
		add_row(127, 128, 128);
		add_row(10, 200, 200);
		add_row(200, 10, 200);
		add_row(0, 1, 255);
		add_row(170, 85, 0);
		foreach (dir_rows[i]) begin
			send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b);
			if (dir_rows[i].known) begin
				hsl_t p;
				p = convert_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b);
				if (p !== dir_rows[i].res) report_mismatch("table row hue", p.hue, dir_rows[i].res.hue);
			end
		end

		// pause until the pipe drains
		pix_valid <= 1'b0;
		wait (hsl_expected.size() == 0);
		@(posedge clk);

		for (int i = 0; i < RandItems; i++) begin
			if (i == RandItems / 4) start_hold = 1;
			if (i == RandItems * 3 / 4) quiet = 1;
			c = $urandom_range(0, 5);
			case (c)
				0: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
				1: begin
					logic [7:0] v;
					v = 8'($urandom);
					send_pixel(v, v, v);
				end
				2: begin
					logic [7:0] v;
					v = 8'($urandom);
					send_pixel(v, v, 8'($urandom));
				end
				3: send_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
						8'($urandom_range(0, 3)));
				4: send_pixel(8'($urandom_range(252, 255)), 8'($urandom_range(252, 255)),
						8'($urandom_range(0, 255)));
				default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
		end
		pix_valid <= 1'b0;
		stim_done = 1;
		wait (hsl_expected.size() == 0);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("rgb_to_hsl_pixel_test: PASS");
		else
			$display("rgb_to_hsl_pixel_test: FAIL");
		$finish;
	end

endmodule
